// ----- sv/sidu_pkg.sv -----
// shared types for the signed integer divider unit
package sidu_pkg;

  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } sidu_ctl_t;

endpackage

// ----- sv/sidu_prep.sv -----
// operand stage: magnitudes, result sign and zero detection
module sidu_prep #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output sidu_pkg::sidu_ctl_t          ctl,
  output logic        [DATA_WIDTH-1:0] mag_a,
  output logic        [DATA_WIDTH-1:0] mag_b
);
  import sidu_pkg::*;

  sidu_ctl_t             ctl_next;
  logic [DATA_WIDTH-1:0] a_u;
  logic [DATA_WIDTH-1:0] b_u;
  logic [DATA_WIDTH-1:0] mag_a_next;
  logic [DATA_WIDTH-1:0] mag_b_next;

  always_comb begin
    a_u            = $unsigned(dividend);
    b_u            = $unsigned(divisor);
    ctl_next.valid = in_valid;
    ctl_next.neg   = a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
    ctl_next.zero  = (a_u == '0) || (b_u == '0);
    mag_a_next     = a_u[DATA_WIDTH-1] ? (~a_u + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : a_u;
    mag_b_next     = b_u[DATA_WIDTH-1] ? (~b_u + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : b_u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    mag_a <= mag_a_next;
    mag_b <= mag_b_next;
  end

endmodule

// ----- sv/sidu_step.sv -----
// one restoring division step: one quotient bit per stage
module sidu_step #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sidu_pkg::sidu_ctl_t   ctl_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] dq_in,
  input  logic [DATA_WIDTH-1:0] dvs_in,
  output sidu_pkg::sidu_ctl_t   ctl,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH-1:0] dq,
  output logic [DATA_WIDTH-1:0] dvs
);
  import sidu_pkg::*;

  logic [DATA_WIDTH:0]   trial;
  logic                  take;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] dq_next;

  always_comb begin
    trial    = {rem_in, dq_in[DATA_WIDTH-1]} - {1'b0, dvs_in};
    take     = !trial[DATA_WIDTH];
    rem_next = take ? trial[DATA_WIDTH-1:0] : {rem_in[DATA_WIDTH-2:0], dq_in[DATA_WIDTH-1]};
    dq_next  = {dq_in[DATA_WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    dq  <= dq_next;
    dvs <= dvs_in;
  end

endmodule

// ----- sv/sidu_fix.sv -----
// output stage: sign, zero cases and saturation
module sidu_fix #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sidu_pkg::sidu_ctl_t          ctl_in,
  input  logic        [DATA_WIDTH-1:0] q_in,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quotient
);
  import sidu_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic [DATA_WIDTH-1:0] quotient_next;

  always_comb begin
    priority if (ctl_in.zero) begin
      quotient_next = '0;
    end else if (ctl_in.neg) begin
      quotient_next = ~q_in + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    end else if (q_in[DATA_WIDTH-1]) begin
      quotient_next = MaxPos;
    end else begin
      quotient_next = q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    quotient <= $signed(quotient_next);
  end

endmodule

// ----- sv/signed_integer_divider_unit.sv -----
// top level of the pipelined signed integer divider
// One division enters per clock: a transfer happens when start is high and busy is low,
// and busy is high only while in reset and the cycle after. The quotient (truncated
// toward zero) appears on quotient with done high for exactly one cycle, after one operand
// stage, one restoring subtract step per quotient bit, and one sign and saturation stage.
// Results cannot be held off, and results come out in the order the operands went in. A
// zero dividend or divisor gives 0; the most negative value divided by -1 gives the largest
// positive value.
module signed_integer_divider_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quotient
);
  import sidu_pkg::*;

  sidu_ctl_t             ctl [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dq  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dvs [0:DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  sidu_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .dividend (dividend),
    .divisor  (divisor),
    .ctl      (ctl[0]),
    .mag_a    (dq[0]),
    .mag_b    (dvs[0])
  );

  assign rem[0] = '0;

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    sidu_step #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_step (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl[i]),
      .rem_in (rem[i]),
      .dq_in  (dq[i]),
      .dvs_in (dvs[i]),
      .ctl    (ctl[i+1]),
      .rem    (rem[i+1]),
      .dq     (dq[i+1]),
      .dvs    (dvs[i+1])
    );
  end

  sidu_fix #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_fix (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl[DATA_WIDTH]),
    .q_in     (dq[DATA_WIDTH]),
    .done     (done),
    .quotient (quotient)
  );

endmodule

// ----- sv/sidu_checker.sv -----
// port-level checks for the signed integer divider unit, with bind
module sidu_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic signed [DATA_WIDTH-1:0] dividend,
  input logic signed [DATA_WIDTH-1:0] divisor,
  input logic                         done,
  input logic signed [DATA_WIDTH-1:0] quotient
);

  localparam int Latency = DATA_WIDTH + 2;
  localparam logic [DATA_WIDTH-1:0] MinNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic xfer;
  assign xfer = start && !busy;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    xfer |-> ##Latency done)
    else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !xfer |-> ##Latency !done)
    else $error("result without transfer");

  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    (xfer && (divisor == '0)) |-> ##Latency (quotient == '0))
    else $error("zero divisor did not give zero");

  a_saturate: assert property (@(posedge clk) disable iff (rst)
    (xfer && ($unsigned(dividend) == MinNeg) && ($unsigned(divisor) == '1))
      |-> ##Latency ($unsigned(quotient) == MaxPos))
    else $error("overflow case not saturated");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    (xfer && (dividend[DATA_WIDTH-1] == divisor[DATA_WIDTH-1]))
      |-> ##Latency !quotient[DATA_WIDTH-1])
    else $error("same-sign operands gave negative quotient");

endmodule

bind signed_integer_divider_unit sidu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sidu_checker (.*);

// ----- verif/signed_integer_divider_unit_tb.sv -----
// testbench for the signed integer divider unit: directed and random divisions checked by a predictor
`timescale 1ns / 100ps

module signed_integer_divider_unit_tb;

  localparam int W = 32;
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic [W-1:0] quotient;
  } division_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic signed [W-1:0] dividend;
  logic signed [W-1:0] divisor;
  logic                done;
  logic signed [W-1:0] quotient;

  division_t pending_quotients[$];
  int        failures = 0;
  int        divisions_sent;
  int        quotients_checked = 0;
  int        zero_cases;
  int        saturated_cases;
  int        idle_cycles = 0;
  bit        back_to_back;

  signed_integer_divider_unit #(
    .DATA_WIDTH(W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .dividend(dividend),
    .divisor (divisor),
    .done    (done),
    .quotient(quotient)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [W-1:0] truncated_quotient(logic [W-1:0] num, logic [W-1:0] den);
    logic         num_neg;
    logic         den_neg;
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [W-1:0] q;
    num_neg = num[W-1];
    den_neg = den[W-1];
    if (num == '0 || den == '0) return '0;
    num_mag = num_neg ? -num : num;
    den_mag = den_neg ? -den : den;
    q = num_mag / den_mag;
    if (num_neg != den_neg) q = -q;
    else if (q > MOST_POS) q = MOST_POS;
    return q;
  endfunction

  task automatic send_division(input logic [W-1:0] num, input logic [W-1:0] den);
    division_t item;
    int        gap;
    gap = back_to_back ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    dividend <= num;
    divisor  <= den;
    do @(posedge clk); while (busy);
    item.dividend = num;
    item.divisor  = den;
    item.quotient = truncated_quotient(num, den);
    if (num == '0 || den == '0) zero_cases++;
    if (num == MOST_NEG && den == MINUS_ONE) saturated_cases++;
    pending_quotients.insert(pending_quotients.size(), item);
    divisions_sent++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk);
  endtask

  function automatic logic [W-1:0] random_signed_operand();
    logic [W-1:0] v;
    v = $urandom() >> $urandom_range(0, W - 1);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic test_directed();
    logic [W-1:0] nums[$];
    logic [W-1:0] dens[$];
    nums = '{MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, '0, 32'd5, MOST_NEG,
             MOST_POS, 32'd7, -32'sd7, 32'd7, -32'sd7, 32'd1, MINUS_ONE, MOST_NEG,
             32'd100, 32'd3, MINUS_ONE, MOST_POS, 32'hAAAA_AAAA, 32'h5555_5555};
    dens = '{MINUS_ONE, 32'd1, MOST_NEG, MOST_POS, MINUS_ONE, 32'd9, '0, MOST_POS,
             MOST_NEG, -32'sd2, 32'd2, 32'd2, -32'sd2, MOST_POS, MOST_NEG, '0,
             32'd100, 32'd7, MINUS_ONE, 32'd1, 32'h5555_5555, 32'hAAAA_AAAA};
    back_to_back = 1'b0;
    foreach (nums[i]) send_division(nums[i], dens[i]);
    wait_for_results();
  endtask

  task automatic test_full_range(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      send_division($urandom(), $urandom());
    end
  endtask

  task automatic test_magnitude_sweep(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      send_division(random_signed_operand(), random_signed_operand());
    end
  endtask

  task automatic test_special_operands(input int count);
    logic [W-1:0] num;
    logic [W-1:0] den;
    back_to_back = 1'b0;
    for (int i = 0; i < count; i++) begin
      num = $urandom();
      den = $urandom();
      case ($urandom_range(0, 5))
        0: num = '0;
        1: den = '0;
        2: begin
          num = MOST_NEG;
          den = MINUS_ONE;
        end
        3: num = MOST_NEG;
        4: den = $urandom_range(0, 1) ? MINUS_ONE : 32'd1;
        default: den = num;
      endcase
      send_division(num, den);
    end
  endtask

  task automatic test_back_to_back(input int count);
    back_to_back = 1'b1;
    for (int i = 0; i < count; i++) send_division(random_signed_operand(), $urandom());
    back_to_back = 1'b0;
  endtask

  always @(posedge clk) begin
    division_t item;
    if (!rst && done === 1'b1) begin
      if (pending_quotients.size() == 0) begin
        $error("quotient transfer with nothing pending: actual %0d", quotient);
        failures++;
      end else begin
        item = pending_quotients.pop_front();
        quotients_checked++;
        if (quotient !== item.quotient) begin
          $error("quotient (%0d / %0d): expected %0d actual %0d",
                 $signed(item.dividend), $signed(item.divisor),
                 $signed(item.quotient), quotient);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    divisions_sent    = 0;
    zero_cases        = 0;
    saturated_cases   = 0;
    back_to_back      = 1'b0;
    rst      <= 1'b1;
    start    <= 1'b0;
    dividend <= '0;
    divisor  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_range(500);
    test_magnitude_sweep(500);
    wait_for_results();
    test_special_operands(230);
    test_back_to_back(300);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d divisions, %0d quotients checked", divisions_sent, quotients_checked);
    $display("zero operand cases %0d, saturating cases %0d", zero_cases, saturated_cases);
    if (failures == 0 && pending_quotients.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (pending_quotients.size() != 0)
        $error("quotient: %0d expected results never arrived", pending_quotients.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
